// ===== rtl/core/pph_pkg.sv =====
package pph_pkg;

  localparam int MAX_POINTS_DEF   = 2048;
  localparam int CORDIC_STEPS_DEF = 16;

  // Register reset values
  localparam logic [15:0] LOOK_RST  = 16'd1229;
  localparam logic [15:0] WHEEL_RST = 16'd614;
  localparam logic [15:0] CELL_RST  = 16'd205;

  // Request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_LENGTH = 2'd1;
  localparam logic [1:0] REQ_POSE   = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_LOOK  = 2'd0;
  localparam logic [1:0] CFG_WHEEL = 2'd1;
  localparam logic [1:0] CFG_CELL  = 2'd2;

  // Angles in 2^-28 rad
  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic [29:0]        INV_GAIN    = 30'd652032874;
  localparam logic signed [13:0] HEAD_LIMIT  = 14'sd6434;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TAKE,
    OP_READ_I,
    OP_READ_IDX,
    OP_NEXT,
    OP_HIT,
    OP_MISS,
    OP_ROT_INIT,
    OP_REDUCE,
    OP_ROT_STEP,
    OP_GAIN_HI,
    OP_GAIN_LO,
    OP_NUM_HI,
    OP_NUM_LO,
    OP_ATAN_INIT,
    OP_ATAN_STEP,
    OP_FINISH,
    OP_EMPTY
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic i_in_range;
    logic qualifies;
    logic z_high;
    logic z_low;
    logic k_last;
    logic out_free;
  } stat_t;

  // Arctangent of 2^-k in 2^-28 rad
  function automatic logic [27:0] atan_entry(input logic [4:0] k);
    logic [27:0] v;
    unique case (k)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/pph_ifs.sv =====
interface pph_req_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [10:0]        wp_index;
  logic signed [15:0] wp_x;
  logic signed [15:0] wp_y;
  logic [11:0]        new_length;
  logic signed [23:0] pose_x;
  logic signed [23:0] pose_y;
  logic signed [15:0] pose_angle;

  modport source (input clk, ready, output valid, req_type, wp_index, wp_x, wp_y,
                  new_length, pose_x, pose_y, pose_angle);
  modport sink (input clk, valid, req_type, wp_index, wp_x, wp_y, new_length,
                pose_x, pose_y, pose_angle, output ready);
endinterface

interface pph_res_if (input logic clk);
  logic               valid;
  logic               ready;
  logic signed [13:0] steer_heading;
  logic [10:0]        target_index;
  logic               no_path;

  modport source (input clk, ready, output valid, steer_heading, target_index, no_path);
  modport sink (input clk, valid, steer_heading, target_index, no_path, output ready);
endinterface

// ===== rtl/core/pph_ctrl.sv =====
module pph_ctrl
  import pph_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_is_pose,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_WAIT, S_TEST, S_FINAL, S_ROTI, S_REDUCE, S_ROT,
    S_GHI, S_GLO, S_NHI, S_NLO, S_ATI, S_ATAN, S_DONE, S_EMPTY
  } state_t;

  state_t     state, state_next;
  logic [1:0] wcnt, wcnt_next;
  logic       fin, fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wcnt  <= '0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      wcnt  <= wcnt_next;
      fin   <= fin_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequence the walk, rotation, scaling and arctangent
  always_comb begin
    state_next = state;
    wcnt_next  = wcnt;
    fin_next   = fin;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_TAKE;
          if (in_is_pose) state_next = stat.count_zero ? S_EMPTY : S_WALK;
        end
      end
      S_WALK: begin
        if (stat.i_in_range) begin
          cmd.op     = OP_READ_I;
          wcnt_next  = 2'd3;
          fin_next   = 1'b0;
          state_next = S_WAIT;
        end else begin
          cmd.op     = OP_MISS;
          state_next = S_FINAL;
        end
      end
      S_WAIT: begin
        if (wcnt == 2'd0) state_next = fin ? S_ROTI : S_TEST;
        else wcnt_next = wcnt - 2'd1;
      end
      S_TEST: begin
        if (stat.qualifies) begin
          cmd.op     = OP_HIT;
          state_next = S_FINAL;
        end else begin
          cmd.op     = OP_NEXT;
          state_next = S_WALK;
        end
      end
      S_FINAL: begin
        cmd.op     = OP_READ_IDX;
        wcnt_next  = 2'd3;
        fin_next   = 1'b1;
        state_next = S_WAIT;
      end
      S_ROTI: begin
        cmd.op     = OP_ROT_INIT;
        state_next = S_REDUCE;
      end
      S_REDUCE: begin
        if (stat.z_high || stat.z_low) cmd.op = OP_REDUCE;
        else state_next = S_ROT;
      end
      S_ROT: begin
        cmd.op = OP_ROT_STEP;
        if (stat.k_last) state_next = S_GHI;
      end
      S_GHI: begin
        cmd.op     = OP_GAIN_HI;
        state_next = S_GLO;
      end
      S_GLO: begin
        cmd.op     = OP_GAIN_LO;
        state_next = S_NHI;
      end
      S_NHI: begin
        cmd.op     = OP_NUM_HI;
        state_next = S_NLO;
      end
      S_NLO: begin
        cmd.op     = OP_NUM_LO;
        state_next = S_ATI;
      end
      S_ATI: begin
        cmd.op     = OP_ATAN_INIT;
        state_next = S_ATAN;
      end
      S_ATAN: begin
        cmd.op = OP_ATAN_STEP;
        if (stat.k_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.op     = OP_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/pph_dp.sv =====
module pph_dp
  import pph_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         in_type,
  input  logic [10:0]        in_wp_index,
  input  logic signed [15:0] in_wp_x,
  input  logic signed [15:0] in_wp_y,
  input  logic [11:0]        in_new_length,
  input  logic signed [23:0] in_pose_x,
  input  logic signed [23:0] in_pose_y,
  input  logic signed [15:0] in_pose_angle,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [13:0] out_heading,
  output logic [10:0]        out_index,
  output logic               out_no_path
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CNW = AW + 1;
  localparam int LW  = (CNW > 12) ? CNW : 12;
  localparam int KW  = $clog2(CORDIC_STEPS);

  // Waypoint memories
  logic signed [15:0] path_x [MAX_POINTS];
  logic signed [15:0] path_y [MAX_POINTS];

  logic [15:0]        look, wheel, cell_sz;
  logic [CNW-1:0]     count;
  logic [AW-1:0]      cur_target;
  logic [CNW-1:0]     walk_i;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      addr;
  logic signed [15:0] rd_x, rd_y;
  logic signed [32:0] sx, sy;
  logic signed [34:0] dx, dy;
  logic [34:0]        mag_x, mag_y;
  logic               big_x, big_y;
  logic [31:0]        sq_x, sq_y;
  logic [31:0]        l2;
  logic signed [23:0] pos_x, pos_y;
  logic signed [15:0] ang;
  logic signed [63:0] x, y;
  logic signed [33:0] z;
  logic [KW-1:0]      k;
  logic signed [33:0] tab;
  logic signed [63:0] x_sh, y_sh;
  logic signed [19:0] mul_a;
  logic signed [30:0] mul_b;
  logic signed [50:0] mul_p, prod;
  logic signed [67:0] lin_sum;
  logic signed [37:0] ly;
  logic signed [55:0] num;
  logic signed [33:0] z_rnd;
  logic signed [13:0] head;
  logic               take, wr_ok;
  logic [AW-1:0]      wslot;

  assign take  = (cmd.op == OP_TAKE);
  assign wr_ok = LW'(in_wp_index) < LW'(MAX_POINTS);
  assign wslot = AW'(in_wp_index);

  // Write waypoints
  always_ff @(posedge clk) begin
    if (take && in_type == REQ_WRITE && wr_ok) begin
      path_x[wslot] <= in_wp_x;
      path_y[wslot] <= in_wp_y;
    end
    rd_x <= path_x[addr];
    rd_y <= path_y[addr];
  end

  // Distance pipeline: scale, offset, square
  assign mag_x = dx[34] ? 35'(-dx) : 35'(dx);
  assign mag_y = dy[34] ? 35'(-dy) : 35'(dy);

  always_ff @(posedge clk) begin
    sx    <= rd_x * $signed({1'b0, cell_sz});
    sy    <= rd_y * $signed({1'b0, cell_sz});
    dx    <= sx - pos_x;
    dy    <= sy - pos_y;
    big_x <= |mag_x[34:16];
    big_y <= |mag_y[34:16];
    sq_x  <= mag_x[15:0] * mag_x[15:0];
    sq_y  <= mag_y[15:0] * mag_y[15:0];
  end

  // Shared CORDIC shifter and multiplier
  assign tab  = $signed({6'b0, atan_entry(5'(k))});
  assign x_sh = x >>> k;
  assign y_sh = y >>> k;

  always_comb begin
    unique case (cmd.op)
      OP_GAIN_HI: begin
        mul_a = $signed({y[36], y[36:18]});
        mul_b = $signed({1'b0, INV_GAIN});
      end
      OP_GAIN_LO: begin
        mul_a = $signed({2'b0, y[17:0]});
        mul_b = $signed({1'b0, INV_GAIN});
      end
      OP_NUM_HI: begin
        mul_a = ly[37:18];
        mul_b = $signed({15'b0, wheel});
      end
      OP_NUM_LO: begin
        mul_a = $signed({2'b0, ly[17:0]});
        mul_b = $signed({15'b0, wheel});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign lin_sum = (68'(prod) <<< 18) + 68'(mul_p);

  // Round and clamp the angle; a zero numerator gives a zero heading
  assign z_rnd = (z + 34'sd32768) >>> 16;
  always_comb begin
    if (num == '0) head = '0;
    else if (z_rnd > 34'(HEAD_LIMIT)) head = HEAD_LIMIT;
    else if (z_rnd < -34'(HEAD_LIMIT)) head = -HEAD_LIMIT;
    else head = 14'(z_rnd);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      look       <= LOOK_RST;
      wheel      <= WHEEL_RST;
      cell_sz    <= CELL_RST;
      count      <= '0;
      cur_target <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOOK:  look    <= cfg_data;
          CFG_WHEEL: wheel   <= cfg_data;
          CFG_CELL:  cell_sz <= cfg_data;
          default: ;
        endcase
      end
      if (take && in_type == REQ_LENGTH) begin
        if (LW'(in_new_length) > LW'(MAX_POINTS)) count <= CNW'(MAX_POINTS);
        else count <= CNW'(in_new_length);
      end
      if (cmd.op == OP_READ_IDX) cur_target <= idx;
      if (cmd.op == OP_FINISH || cmd.op == OP_EMPTY) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TAKE: begin
        pos_x  <= in_pose_x;
        pos_y  <= in_pose_y;
        ang    <= in_pose_angle;
        l2     <= look * look;
        walk_i <= CNW'(cur_target);
      end
      OP_READ_I:   addr <= walk_i[AW-1:0];
      OP_READ_IDX: addr <= idx;
      OP_NEXT:     walk_i <= walk_i + 1'b1;
      OP_HIT:      idx <= walk_i[AW-1:0];
      OP_MISS:     idx <= AW'(count - 1'b1);
      OP_ROT_INIT: begin
        x <= 64'(dx);
        y <= 64'(dy);
        z <= (-34'(ang)) <<< 16;
        k <= '0;
      end
      OP_REDUCE: begin
        x <= -x;
        y <= -y;
        if (z > ANG_HALF_PI) z <= z - ANG_PI;
        else z <= z + ANG_PI;
      end
      OP_ROT_STEP: begin
        if (z >= 0) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - tab;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + tab;
        end
        k <= k + 1'b1;
      end
      OP_GAIN_HI: prod <= mul_p;
      OP_GAIN_LO: ly <= 38'((lin_sum + 68'sd536870912) >>> 30);
      OP_NUM_HI:  prod <= mul_p;
      OP_NUM_LO:  num <= 56'(lin_sum);
      OP_ATAN_INIT: begin
        x <= $signed(64'(l2) << 12);
        y <= 64'(num) <<< 13;
        z <= '0;
        k <= '0;
      end
      OP_ATAN_STEP: begin
        if (y >= 0) begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + tab;
        end else begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - tab;
        end
        k <= k + 1'b1;
      end
      OP_FINISH: begin
        out_heading <= head;
        out_index   <= 11'(cur_target);
        out_no_path <= 1'b0;
      end
      OP_EMPTY: begin
        out_heading <= '0;
        out_index   <= 11'(cur_target);
        out_no_path <= 1'b1;
      end
      default: ;
    endcase
  end

  // Status back to the controller
  assign stat.count_zero = (count == '0);
  assign stat.i_in_range = (walk_i < count);
  assign stat.qualifies  = big_x || big_y || ({1'b0, sq_x} + {1'b0, sq_y} >= {1'b0, l2});
  assign stat.z_high     = (z > ANG_HALF_PI);
  assign stat.z_low      = (z < -ANG_HALF_PI);
  assign stat.k_last     = (k == KW'(CORDIC_STEPS - 1));
  assign stat.out_free   = !out_valid || out_ready;

endmodule

// ===== rtl/core/pure_pursuit_heading.sv =====
// Pure-pursuit steering for a stored grid path. Waypoint writes, length writes and
// requests with an unknown code are taken in the idle state without leaving it. A
// pose is taken, then walks from the current target, examining one waypoint at a
// time through the registered memory read, the scaling multiplier and the squaring
// stage, rereads the chosen waypoint, loads the rotator, reduces the heading angle
// by half turns, runs CORDIC_STEPS rotation and CORDIC_STEPS vectoring iterations
// on one shared shift and add unit, forms the inverse-gain and wheelbase products
// in high and low halves on one shared multiplier, loads the vectoring unit and
// rounds into the output register once that register is free. An empty path goes
// straight to a no-path result.
// A finished result waits in an output register while the next item is taken.
module pure_pursuit_heading
  import pph_pkg::*;
#(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pph_req_if.sink     req,
  pph_res_if.source   res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  pph_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_is_pose (req.req_type == REQ_POSE),
    .in_ready   (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pph_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_type       (req.req_type),
    .in_wp_index   (req.wp_index),
    .in_wp_x       (req.wp_x),
    .in_wp_y       (req.wp_y),
    .in_new_length (req.new_length),
    .in_pose_x     (req.pose_x),
    .in_pose_y     (req.pose_y),
    .in_pose_angle (req.pose_angle),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .out_heading   (res.steer_heading),
    .out_index     (res.target_index),
    .out_no_path   (res.no_path)
  );

  // An empty path steers straight
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.no_path |-> res.steer_heading == 14'sd0)
    else $error("empty path result with nonzero heading");

  // Heading stays inside the clamp
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.steer_heading <= HEAD_LIMIT) && (res.steer_heading >= -HEAD_LIMIT))
    else $error("heading outside clamp");

  // A pose beat holds off the next item
  a_pose_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.req_type == REQ_POSE |=> !req.ready)
    else $error("input taken while a pose is in flight");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import pph_pkg::*;

  typedef struct {
    logic [1:0]         req_type;
    logic [10:0]        wp_index;
    logic signed [15:0] wp_x;
    logic signed [15:0] wp_y;
    logic [11:0]        new_length;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] pose_angle;
  } pose_req_t;

  typedef struct {
    logic signed [13:0] steer_heading;
    logic [10:0]        target_index;
    logic               no_path;
  } steer_t;

  // Tracks path state and predicts the steering answer of every pose beat
  class steer_tracker;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint PI_Q28      = 843314857;
    localparam longint GAIN_Q30    = 652032874;
    localparam longint LIMIT       = 6434;
    longint atan_q28 [16] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                              8385879, 4193963, 2097109, 1048571, 524287, 262144,
                              131072, 65536, 32768, 16384, 8192};
    logic signed [15:0] way_x [MAX_POINTS_DEF];
    logic signed [15:0] way_y [MAX_POINTS_DEF];
    bit                 written [MAX_POINTS_DEF];
    int                 path_len;
    int                 target;
    longint             look;
    longint             wheel;
    longint             cell_sz;
    steer_t             expected_steer [$];
    int                 errors;
    int                 poses;
    int                 empties;

    function new();
      path_len = 0;
      target = 0;
      look = LOOK_RST;
      wheel = WHEEL_RST;
      cell_sz = CELL_RST;
      errors = 0;
      poses = 0;
      empties = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == CFG_LOOK) look = val;
      else if (idx == CFG_WHEEL) wheel = val;
      else if (idx == CFG_CELL) cell_sz = val;
    endfunction

    // A pose must never read a slot that was never written
    function bit pose_safe();
      if (path_len == 0) return 1;
      if (target >= path_len) return written[path_len - 1];
      for (int i = target; i < path_len; i++)
        if (!written[i]) return 0;
      return 1;
    endfunction

    function longint unsigned mag_sq(longint v);
      longint unsigned a;
      a = (v < 0) ? -v : v;
      return a * a;
    endfunction

    function longint rotate_y(longint dx, longint dy, longint theta);
      longint z, x, y, t;
      z = -theta * 65536;
      x = dx;
      y = dy;
      while (z > HALF_PI_Q28) begin
        z -= PI_Q28; x = -x; y = -y;
      end
      while (z < -HALF_PI_Q28) begin
        z += PI_Q28; x = -x; y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_q28[i];
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_q28[i];
        end
      end
      return (y * GAIN_Q30 + 536870912) >>> 30;
    endfunction

    function longint steer_angle(longint num, longint den);
      longint x, y, z, t;
      x = den * 4096;
      y = num * 4096;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        if (y >= 0) begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_q28[i];
        end else begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_q28[i];
        end
      end
      z = (z + 32768) >>> 16;
      if (z > LIMIT) z = LIMIT;
      if (z < -LIMIT) z = -LIMIT;
      return z;
    endfunction

    function void note_request(pose_req_t r);
      steer_t e;
      longint px, py, dx, dy, ly, num, hd;
      longint unsigned l2;
      int pick;
      if (r.req_type == REQ_WRITE) begin
        way_x[r.wp_index] = r.wp_x;
        way_y[r.wp_index] = r.wp_y;
        written[r.wp_index] = 1;
        return;
      end
      if (r.req_type == REQ_LENGTH) begin
        path_len = (r.new_length > MAX_POINTS_DEF) ? MAX_POINTS_DEF : r.new_length;
        return;
      end
      if (r.req_type != REQ_POSE) return;
      poses++;
      if (path_len == 0) begin
        empties++;
        e.steer_heading = '0;
        e.target_index = target[10:0];
        e.no_path = 1'b1;
        expected_steer.push_back(e);
        return;
      end
      px = r.pose_x;
      py = r.pose_y;
      l2 = look * look;
      // Walk forward to the first waypoint at or beyond the lookahead
      pick = path_len - 1;
      for (int i = target; i < path_len; i++) begin
        dx = longint'(way_x[i]) * cell_sz - px;
        dy = longint'(way_y[i]) * cell_sz - py;
        if (mag_sq(dx) + mag_sq(dy) >= l2) begin
          pick = i;
          break;
        end
      end
      target = pick;
      dx = longint'(way_x[pick]) * cell_sz - px;
      dy = longint'(way_y[pick]) * cell_sz - py;
      ly = rotate_y(dx, dy, longint'(r.pose_angle));
      num = 2 * wheel * ly;
      hd = (num == 0) ? 0 : steer_angle(num, longint'(l2));
      e.steer_heading = hd[13:0];
      e.target_index = pick[10:0];
      e.no_path = 1'b0;
      expected_steer.push_back(e);
    endfunction

    function void check_heading(steer_t got);
      steer_t e;
      if (expected_steer.size() == 0) begin
        $error("result beat with nothing expected: heading %0d index %0d",
               got.steer_heading, got.target_index);
        errors++;
        return;
      end
      e = expected_steer.pop_front();
      if (got.steer_heading !== e.steer_heading) begin
        $error("steer_heading expected %0d actual %0d", e.steer_heading, got.steer_heading);
        errors++;
      end
      if (got.target_index !== e.target_index) begin
        $error("target_index expected %0d actual %0d", e.target_index, got.target_index);
        errors++;
      end
      if (got.no_path !== e.no_path) begin
        $error("no_path expected %0d actual %0d", e.no_path, got.no_path);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  pph_req_if rq (clk);
  pph_res_if rs (clk);

  pure_pursuit_heading dut (
    .clk       (clk),
    .rst       (rst),
    .req       (rq),
    .res       (rs),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  steer_tracker tracker = new();

  int send_idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_start;
  int quiet_cycles;
  int sent_items;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Observe accepted beats on both channels
  always @(posedge clk) begin
    pose_req_t r;
    steer_t o;
    if (!rst) begin
      if (rq.valid && rq.ready) begin
        r.req_type = rq.req_type;
        r.wp_index = rq.wp_index;
        r.wp_x = rq.wp_x;
        r.wp_y = rq.wp_y;
        r.new_length = rq.new_length;
        r.pose_x = rq.pose_x;
        r.pose_y = rq.pose_y;
        r.pose_angle = rq.pose_angle;
        tracker.note_request(r);
      end
      if (rs.valid && rs.ready) begin
        o.steer_heading = rs.steer_heading;
        o.target_index = rs.target_index;
        o.no_path = rs.no_path;
        tracker.check_heading(o);
      end
    end
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || (rq.valid && rq.ready) || (rs.valid && rs.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      rs.ready = 1'b0;
    end else begin
      rs.ready = ($urandom_range(99, 0) >= stall_pct);
    end
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic pose_req_t mk(logic [1:0] rt, int idx, int wx, int wy, int nl,
                                   int px, int py, int pa);
    pose_req_t r;
    r.req_type = rt;
    r.wp_index = 11'(idx);
    r.wp_x = 16'(wx);
    r.wp_y = 16'(wy);
    r.new_length = 12'(nl);
    r.pose_x = 24'(px);
    r.pose_y = 24'(py);
    r.pose_angle = 16'(pa);
    return r;
  endfunction

  // Drive one request beat; entered and left at a falling edge
  task automatic push(pose_req_t r);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      rq.valid = 1'b0;
      repeat (rnd(1, 4)) @(negedge clk);
    end
    rq.req_type = r.req_type;
    rq.wp_index = r.wp_index;
    rq.wp_x = r.wp_x;
    rq.wp_y = r.wp_y;
    rq.new_length = r.new_length;
    rq.pose_x = r.pose_x;
    rq.pose_y = r.pose_y;
    rq.pose_angle = r.pose_angle;
    rq.valid = 1'b1;
    do @(posedge clk); while (!rq.ready);
    @(negedge clk);
    if (r.req_type != 2'd3) sent_items++;
  endtask

  // Let the block drain, then write the registers
  task automatic write_regs(int look, int wheel, int cell_len);
    rq.valid = 1'b0;
    while (tracker.expected_steer.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_LOOK;
    cfg_data = 16'(look);
    @(negedge clk);
    tracker.set_reg(CFG_LOOK, 16'(look));
    cfg_index = CFG_WHEEL;
    cfg_data = 16'(wheel);
    @(negedge clk);
    tracker.set_reg(CFG_WHEEL, 16'(wheel));
    cfg_index = CFG_CELL;
    cfg_data = 16'(cell_len);
    @(negedge clk);
    tracker.set_reg(CFG_CELL, 16'(cell_len));
    cfg_we = 1'b0;
  endtask

  function automatic int clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  // A pose that would read an unwritten slot turns into an ignored beat
  function automatic pose_req_t random_noise();
    pose_req_t r;
    r = mk(2'(rnd(0, 3)), rnd(0, 2047), rnd(-32768, 32767), rnd(-32768, 32767),
           rnd(0, 4095), rnd(-8388608, 8388607), rnd(-8388608, 8388607),
           rnd(-25736, 25736));
    if (r.req_type == REQ_POSE && !tracker.pose_safe()) r.req_type = 2'd3;
    return r;
  endfunction

  // One well-formed path followed by poses near it
  task automatic path_block();
    int k, cx, cy, j, spread;
    longint bx, by;
    pose_req_t r;
    k = rnd(1, 10);
    cx = rnd(-30, 30);
    cy = rnd(-30, 30);
    for (int i = 0; i < k; i++) begin
      push(mk(REQ_WRITE, i, cx, cy, rnd(0, 4095), rnd(-8388608, 8388607),
              rnd(-8388608, 8388607), rnd(-25736, 25736)));
      cx += rnd(-3, 3);
      cy += rnd(-3, 3);
    end
    if ($urandom_range(99, 0) < 15) push(random_noise());
    push(mk(REQ_LENGTH, rnd(0, 2047), rnd(-32768, 32767), rnd(-32768, 32767), k,
            0, 0, 0));
    repeat (rnd(3, 8)) begin
      if ($urandom_range(99, 0) < 15) begin
        push(random_noise());
      end else begin
        j = rnd(0, k - 1);
        bx = longint'(tracker.way_x[j]) * tracker.cell_sz;
        by = longint'(tracker.way_y[j]) * tracker.cell_sz;
        spread = int'(tracker.look) * 2 + 64;
        r = mk(REQ_POSE, rnd(0, 2047), rnd(-32768, 32767), rnd(-32768, 32767),
               rnd(0, 4095), clamp24(bx + rnd(-spread, spread)),
               clamp24(by + rnd(-spread, spread)), rnd(-25736, 25736));
        if (!tracker.pose_safe()) r.req_type = 2'd3;
        push(r);
      end
    end
  endtask

  int look_set [8]  = '{1229, 1, 65535, 65535, 1, 400, 2000, 800};
  int wheel_set [8] = '{614, 65535, 0, 65535, 0, 3000, 200, 1000};
  int cell_set [8]  = '{205, 1, 65535, 1, 65535, 50, 205, 100};
  int send_set [4]  = '{0, 49, 0, 38};
  int stall_set [4] = '{0, 0, 49, 38};

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_LOOK;
    cfg_data = '0;
    rq.valid = 1'b0;
    rq.req_type = REQ_WRITE;
    rq.wp_index = '0;
    rq.wp_x = '0;
    rq.wp_y = '0;
    rq.new_length = '0;
    rq.pose_x = '0;
    rq.pose_y = '0;
    rq.pose_angle = '0;
    rs.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_start = 0;
    quiet_cycles = 0;
    sent_items = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty path, extremes, saturation, shortened path, ignored code
    push(mk(REQ_POSE, 0, 0, 0, 0, 1000, -1000, 100));
    push(mk(REQ_LENGTH, 0, 0, 0, 0, 0, 0, 0));
    push(mk(REQ_POSE, 0, 0, 0, 0, 8388607, -8388608, 25736));
    push(mk(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0));
    push(mk(REQ_WRITE, 1, 32767, -32768, 0, 0, 0, 0));
    push(mk(REQ_WRITE, 2, -32768, 32767, 0, 0, 0, 0));
    push(mk(REQ_WRITE, 3, 2, 2, 0, 0, 0, 0));
    push(mk(REQ_WRITE, 2047, -1, -1, 4095, -1, -1, -1));
    push(mk(2'd3, 2047, -1, -1, 4095, -1, -1, -1));
    push(mk(REQ_LENGTH, 0, 0, 0, 4, 0, 0, 0));
    push(mk(REQ_POSE, 0, 0, 0, 0, 0, 0, 0));
    push(mk(REQ_POSE, 0, 0, 0, 0, 8388607, 8388607, -25736));
    push(mk(REQ_POSE, 0, 0, 0, 0, -8388608, -8388608, 25736));
    push(mk(REQ_POSE, 0, 0, 0, 0, 410, 410, 0));
    push(mk(REQ_LENGTH, 0, 0, 0, 4095, 0, 0, 0));
    push(mk(REQ_LENGTH, 0, 0, 0, 2, 0, 0, 0));
    push(mk(REQ_POSE, 0, 0, 0, 0, 300, -200, 12868));
    push(mk(REQ_LENGTH, 0, 0, 0, 4, 0, 0, 0));
    push(mk(REQ_POSE, 0, 0, 0, 0, 5000, 5000, -12868));

    for (int p = 0; p < 8; p++) begin
      write_regs(look_set[p], wheel_set[p], cell_set[p]);
      send_idle_pct = send_set[p % 4];
      stall_pct = stall_set[p % 4];
      // Long receiver hold-off while poses keep coming
      if (p == 4) hold_start = 1;
      while (sent_items < 20 + (p + 1) * 105) path_block();
    end

    rq.valid = 1'b0;
    while (tracker.expected_steer.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("tb_top: %0d request beats, %0d poses (%0d on an empty path)",
             sent_items, tracker.poses, tracker.empties);
    $display("tb_top: 8 register settings, four idle and stall mixes, one long hold-off");
    if (tracker.errors == 0 && tracker.expected_steer.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
